// ----- rtl/fixed_block_pool_allocator_unit_defines.svh -----
// Assertion macros for the pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define FBPA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FBPA_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fbpa_pkg.sv -----
// Package: sizes, register indexes, reset values and function codes of the pool allocator.
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int CFG_CNT_W  = 7;
	localparam int OUT_IDX_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int N_W        = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
	localparam int DIV_CNT_W  = $clog2(ADDR_W);

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLK_LEN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

	localparam logic [CFG_CNT_W-1:0] RST_BLOCK_COUNT  = 7'd64;
	localparam logic [SIZE_W-1:0]    RST_BLK_LEN      = 16'd64;
	localparam logic [ADDR_W-1:0]    RST_BASE_ADDRESS = 32'd0;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

// ----- rtl/fbpa_if.sv -----
// Request and response channel interfaces of the pool allocator.
interface fbpa_req_if;
	import fbpa_pkg::*;
	logic              valid;
	logic              ready;
	logic              func;
	logic [ADDR_W-1:0] block_address;

	modport source (output valid, output func, output block_address, input ready);
	modport sink (input valid, input func, input block_address, output ready);
endinterface

interface fbpa_rsp_if;
	import fbpa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [OUT_IDX_W-1:0] block_index;
	logic [ADDR_W-1:0]    result_address;

	modport source (output valid, output ok, output block_index, output result_address,
		input ready);
	modport sink (input valid, input ok, input block_index, input result_address,
		output ready);
endinterface

// ----- rtl/fixed_block_pool_allocator_unit.sv -----
// Top level: fixed-size block pool allocator with a shared add/sub unit.
//
// req carries func (0 allocate, 1 free) and block_address; rsp returns ok,
// block_index and result_address, one response per request item.
// Configuration: cfg_write with cfg_index and cfg_data writes block_count,
// the block length or base_address; write only while the block is idle.
// An allocate scans the free map one block a cycle up to block_count, capped
// at MAX_BLOCKS, and stops at the first free block, stepping the address with
// the add/sub unit. A free runs one offset subtract, 32 restoring division
// steps and one range check, all through the same 33-bit add/sub unit, and
// then an output step. A free with a zero block length skips them and fails.
// One item is worked on at a time; req.ready is high while the sequencer is
// idle, and a new item is taken even while the last response still waits.
// A stalled rsp holds its item and the sequencer waits with the next result.
// Reset (arst_n low) marks every block free and loads the register defaults.
`include "fixed_block_pool_allocator_unit_defines.svh"

module fixed_block_pool_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data,
	fbpa_req_if.sink                         req,
	fbpa_rsp_if.source                       rsp
);
	import fbpa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_OFFSET,
		ST_DIV,
		ST_CHECK,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic [CFG_CNT_W-1:0]   block_count_q;
	logic [SIZE_W-1:0]      blk_len_q;
	logic [ADDR_W-1:0]      base_address_q;
	logic [MAX_BLOCKS-1:0]  free_map_q;

	logic [N_W-1:0]         scan_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [ADDR_W-1:0]      quo_q;
	logic [SIZE_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	logic                   r_ok_q;
	logic [OUT_IDX_W-1:0]   r_idx_q;
	logic [ADDR_W-1:0]      r_addr_q;

	logic                   out_valid_q;
	logic                   out_ok_q;
	logic [OUT_IDX_W-1:0]   out_idx_q;
	logic [ADDR_W-1:0]      out_addr_q;

	logic [N_W-1:0]         n_use;
	logic [ADDR_W-1:0]      op_a;
	logic [ADDR_W-1:0]      op_b;
	logic                   op_sub;
	logic [ADDR_W:0]        op_sum;
	logic                   scan_hit;
	logic                   scan_end;
	logic                   in_acc;

	assign n_use = (N_W'(block_count_q) > N_W'(MAX_BLOCKS)) ? N_W'(MAX_BLOCKS)
		: N_W'(block_count_q);

	assign in_acc   = req.valid && req.ready;
	assign scan_end = (scan_q >= n_use);
	assign scan_hit = !scan_end && free_map_q[scan_q[IDX_W-1:0]];

	// shared add/sub unit, operands chosen by the sequencer
	always_comb begin
		op_a   = addr_q;
		op_b   = ADDR_W'(blk_len_q);
		op_sub = 1'b0;
		case (state_q)
			ST_OFFSET: begin
				op_a   = quo_q;
				op_b   = base_address_q;
				op_sub = 1'b1;
			end
			ST_DIV: begin
				op_a   = {{(ADDR_W-SIZE_W-1){1'b0}}, rem_q, quo_q[ADDR_W-1]};
				op_b   = ADDR_W'(blk_len_q);
				op_sub = 1'b1;
			end
			ST_CHECK: begin
				op_a   = quo_q;
				op_b   = ADDR_W'(n_use);
				op_sub = 1'b1;
			end
			default: begin
				op_a   = addr_q;
				op_b   = ADDR_W'(blk_len_q);
				op_sub = 1'b0;
			end
		endcase
	end

	assign op_sum = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = out_ok_q;
	assign rsp.block_index    = out_idx_q;
	assign rsp.result_address = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			block_count_q  <= RST_BLOCK_COUNT;
			blk_len_q      <= RST_BLK_LEN;
			base_address_q <= RST_BASE_ADDRESS;
			free_map_q     <= '1;
			out_valid_q    <= 1'b0;
			out_ok_q       <= 1'b0;
			out_idx_q      <= '0;
			out_addr_q     <= '0;
			r_ok_q         <= 1'b0;
			r_idx_q        <= '0;
			r_addr_q       <= '0;
			addr_q         <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			scan_q         <= '0;
			div_cnt_q      <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_BLOCK_COUNT:  block_count_q  <= cfg_data[CFG_CNT_W-1:0];
					REG_BLK_LEN:      blk_len_q      <= cfg_data[SIZE_W-1:0];
					REG_BASE_ADDRESS: base_address_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && rsp.ready && (state_q != ST_OUT))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_q    <= '0;
						addr_q    <= base_address_q;
						quo_q     <= req.block_address;
						rem_q     <= '0;
						div_cnt_q <= '0;
						r_ok_q    <= 1'b0;
						r_idx_q   <= '0;
						r_addr_q  <= '0;
						if (req.func == FUNC_ALLOC)
							state_q <= ST_ALLOC;
						else if (blk_len_q == '0)
							state_q <= ST_OUT;
						else
							state_q <= ST_OFFSET;
					end
				end
				ST_ALLOC: begin
					if (scan_end) begin
						state_q <= ST_OUT;
					end else if (scan_hit) begin
						free_map_q[scan_q[IDX_W-1:0]] <= 1'b0;
						r_ok_q   <= 1'b1;
						r_idx_q  <= OUT_IDX_W'(scan_q);
						r_addr_q <= addr_q;
						state_q  <= ST_OUT;
					end else begin
						scan_q <= scan_q + 1'b1;
						addr_q <= op_sum[ADDR_W-1:0];
					end
				end
				ST_OFFSET: begin
					quo_q   <= op_sum[ADDR_W-1:0];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring step: borrow means the trial subtract failed
					if (!op_sum[ADDR_W]) begin
						rem_q <= op_sum[SIZE_W-1:0];
						quo_q <= {quo_q[ADDR_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SIZE_W-2:0], quo_q[ADDR_W-1]};
						quo_q <= {quo_q[ADDR_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(ADDR_W - 1))
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// borrow on quotient minus block count: index in range
					if ((rem_q == '0) && op_sum[ADDR_W]) begin
						free_map_q[quo_q[IDX_W-1:0]] <= 1'b1;
						r_ok_q  <= 1'b1;
						r_idx_q <= OUT_IDX_W'(quo_q);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= r_ok_q;
						out_idx_q   <= r_idx_q;
						out_addr_q  <= r_addr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FBPA_ASSERT(a_fail_zero_index, (rsp.valid && !rsp.ok) |-> (rsp.block_index == '0), "failed response carries a nonzero index")
	`FBPA_ASSERT(a_accept_leaves_idle, (req.valid && req.ready) |=> (state_q != ST_IDLE), "accepted request left the sequencer idle")
	`FBPA_ASSERT(a_alloc_claims, (state_q == ST_ALLOC && scan_hit) |=> !free_map_q[$past(scan_q[IDX_W-1:0])], "allocated block still marked free")
	`FBPA_ASSERT(a_free_marks, (state_q == ST_CHECK && rem_q == '0 && op_sum[ADDR_W]) |=> free_map_q[$past(quo_q[IDX_W-1:0])], "freed block not marked free")

endmodule

// ----- test/tb_top.sv -----
// Testbench for the fixed block pool allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
	import fbpa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic                 ok;
		logic [OUT_IDX_W-1:0] blk;
		logic [ADDR_W-1:0]    addr;
	} grant_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0] cfg_data;

	fbpa_req_if req_ch();
	fbpa_rsp_if rsp_ch();

	fixed_block_pool_allocator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// pool model
	logic [MAX_BLOCKS-1:0] pool_free;
	logic [CFG_CNT_W-1:0]  cnt_reg;
	logic [SIZE_W-1:0]     size_reg;
	logic [ADDR_W-1:0]     base_reg;

	grant_t grant_q[$];
	int     errors;
	int     cycles;
	int     idle_pct;
	int     stall_pct;
	int     hold_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("fixed_block_pool_allocator_unit verification failed");
		$finish;
	end

	function automatic int active_blocks();
		return (cnt_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(cnt_reg);
	endfunction

	function automatic grant_t settle_request(logic fn, logic [ADDR_W-1:0] addr);
		grant_t g;
		int n;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] q;
		g = '0;
		n = active_blocks();
		if (fn == FUNC_ALLOC) begin
			for (int i = 0; i < n; i++) begin
				if (pool_free[i] && !g.ok) begin
					pool_free[i] = 1'b0;
					g.ok = 1'b1;
					g.blk = OUT_IDX_W'(i);
					g.addr = base_reg + 32'(i) * 32'(size_reg);
				end
			end
		end else if (size_reg != 0) begin
			offset = addr - base_reg;
			if (offset % 32'(size_reg) == 0) begin
				q = offset / 32'(size_reg);
				if (q < 32'(n)) begin
					pool_free[q] = 1'b1;
					g.ok = 1'b1;
					g.blk = OUT_IDX_W'(q);
				end
			end
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_grant();
		grant_t want;
		if (grant_q.size() == 0) begin
			report_mismatch("item with no request pending", ADDR_W'(rsp_ch.block_index), '0);
		end else begin
			want = grant_q.pop_front();
			if (rsp_ch.ok !== want.ok)
				report_mismatch("ok", ADDR_W'(rsp_ch.ok), ADDR_W'(want.ok));
			if (rsp_ch.block_index !== want.blk)
				report_mismatch("block_index", ADDR_W'(rsp_ch.block_index),
					ADDR_W'(want.blk));
			if (rsp_ch.result_address !== want.addr)
				report_mismatch("result_address", rsp_ch.result_address, want.addr);
		end
	endtask

	// response side: check on the rising edge, drive ready on the falling edge
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				check_grant();
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				idle_pct = 52;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				idle_pct = 0;
				stall_pct = 52;
			end
			default: begin
				idle_pct = 18;
				stall_pct = 18;
			end
		endcase
	endtask

	task automatic send_request(logic fn, logic [ADDR_W-1:0] addr);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.block_address <= $urandom;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.block_address <= addr;
		do @(posedge clk); while (!req_ch.ready);
		grant_q.push_back(settle_request(fn, addr));
	endtask

	task automatic drain_pool();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_BLOCK_COUNT:  cnt_reg = value[CFG_CNT_W-1:0];
			REG_BLK_LEN:      size_reg = value[SIZE_W-1:0];
			REG_BASE_ADDRESS: base_reg = value;
			default: ;
		endcase
	endtask

	task automatic configure(int count, logic [SIZE_W-1:0] bsize, logic [ADDR_W-1:0] base);
		write_register(REG_BLOCK_COUNT, ADDR_W'(count));
		write_register(REG_BLK_LEN, ADDR_W'(bsize));
		write_register(REG_BASE_ADDRESS, base);
	endtask

	// an allocate, or mostly well-formed frees of taken blocks, some misaligned, out-of-range or stray
	task automatic random_request(int alloc_pct);
		int n;
		int pick;
		int kind;
		int taken[$];
		logic [ADDR_W-1:0] addr;
		n = active_blocks();
		addr = $urandom;
		if ($urandom_range(99) < alloc_pct || n == 0) begin
			send_request(FUNC_ALLOC, addr);
		end else begin
			for (int i = 0; i < n; i++)
				if (!pool_free[i])
					taken.push_back(i);
			if (taken.size() != 0 && $urandom_range(3) != 0)
				pick = taken[$urandom_range(taken.size() - 1)];
			else
				pick = $urandom_range(n - 1);
			kind = $urandom_range(9);
			if (kind < 7)
				addr = base_reg + 32'(pick) * 32'(size_reg);
			else if (kind == 7 && size_reg > 1)
				addr = base_reg + 32'(pick) * 32'(size_reg) + $urandom_range(1, size_reg - 1);
			else if (kind == 8)
				addr = base_reg + 32'(n + $urandom_range(0, 3)) * 32'(size_reg);
			send_request(FUNC_FREE, addr);
		end
	endtask

	task automatic test_reset_state();
		set_idling(IDLE_NONE);
		send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
		send_request(FUNC_ALLOC, 32'h0);
		send_request(FUNC_FREE, 32'd64);
		send_request(FUNC_FREE, 32'd65);
		send_request(FUNC_FREE, 32'd4096);
		send_request(FUNC_FREE, 32'd128);
		send_request(FUNC_ALLOC, 32'h5555_AAAA);
		drain_pool();
	endtask

	task automatic test_register_extremes();
		set_idling(IDLE_BOTH);
		configure(1, 16'hFFFF, 32'hFFFF_FFF0);
		send_request(FUNC_ALLOC, 32'h0);
		send_request(FUNC_FREE, 32'hFFFF_FFF0);
		send_request(FUNC_ALLOC, 32'hAAAA_5555);
		send_request(FUNC_FREE, 32'hFFFF_FFF0 + 32'hFFFF);
		drain_pool();
		write_register(REG_BLOCK_COUNT, 0);
		send_request(FUNC_ALLOC, 32'h0);
		send_request(FUNC_FREE, 32'hFFFF_FFF0);
		drain_pool();
		configure(100, 16'd1, 32'h0);
		send_request(FUNC_ALLOC, 32'h0);
		send_request(FUNC_FREE, 32'd63);
		send_request(FUNC_FREE, 32'd64);
		drain_pool();
		write_register(REG_BLK_LEN, 0);
		write_register(REG_BASE_ADDRESS, 32'h1234_5678);
		send_request(FUNC_ALLOC, 32'h0);
		send_request(FUNC_FREE, 32'h1234_5678);
		drain_pool();
		configure(64, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(FUNC_FREE, 32'hFFFF_FFFF + 32'd63 * 32'hFFFF);
		drain_pool();
	endtask

	// long receiver hold-off fills the block and stalls req
	task automatic test_backpressure();
		configure(16, 16'd256, 32'h8000_0000);
		set_idling(IDLE_NONE);
		@(posedge clk);
		hold_left = 300;
		repeat (20) random_request(60);
		drain_pool();
	endtask

	task automatic test_random_traffic();
		int counts[8];
		int allocs[8];
		logic [SIZE_W-1:0] sizes[8];
		logic [ADDR_W-1:0] bases[8];
		counts = '{64, 1, 4, $urandom_range(1, 64), 64, 16, 127, $urandom_range(1, 64)};
		allocs = '{70, 55, 50, 60, 75, 55, 60, 50};
		sizes = '{SIZE_W'($urandom_range(1, 65535)), 16'hFFFF, 16'd1,
			SIZE_W'($urandom_range(1, 255)), 16'd4096, SIZE_W'($urandom_range(1, 65535)),
			16'hFFFF, SIZE_W'($urandom_range(1, 16))};
		bases = '{$urandom, 32'hFFFF_FF00, 32'h0, $urandom, 32'hFFFF_FFFF, $urandom,
			$urandom, 32'h0};
		for (int p = 0; p < 8; p++) begin
			drain_pool();
			configure(counts[p], sizes[p], bases[p]);
			set_idling(idle_mode_t'(p % 4));
			repeat (225) random_request(allocs[p]);
		end
		drain_pool();
	endtask

	initial begin
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		cfg_write = 1'b0;
		cfg_index = REG_BLOCK_COUNT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ALLOC;
		req_ch.block_address = '0;
		pool_free = '1;
		cnt_reg = RST_BLOCK_COUNT;
		size_reg = RST_BLK_LEN;
		base_reg = RST_BASE_ADDRESS;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();

		repeat (80) @(posedge clk);
		if (grant_q.size() != 0)
			report_mismatch("requests left without response", ADDR_W'(grant_q.size()), '0);
		if (errors == 0)
			$display("fixed_block_pool_allocator_unit verification clean");
		else
			$display("fixed_block_pool_allocator_unit verification failed");
		$finish;
	end

endmodule
